FILE: hdl/sirs_pkg.sv
// shared types, widths and character codes for the signed radix text converter
package sirs_pkg;

  localparam int DIGIT_W = 4;
  localparam int RADIX_W = 5;
  localparam int BASE_W = 8;
  localparam int CHAR_W = 7;
  localparam int POS_W = 6;
  localparam int CHUNK_W = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [BASE_W-1:0] BASE_LO = 8'd2;
  localparam logic [BASE_W-1:0] BASE_HI = 8'd16;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] MINUS_CODE = 7'd45;
  localparam logic [CHAR_W-1:0] ZERO_CODE = 7'd48;
  localparam logic [CHAR_W-1:0] ALPHA_CODE = 7'd55;
  localparam logic [DIGIT_W-1:0] TEN = 4'd10;

  typedef struct packed {
    logic load;
    logic again;
  } div_ctl_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  // uppercase glyph for one digit
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] code;
    if (d < TEN) begin
      code = ZERO_CODE + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    end else begin
      code = ALPHA_CODE + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    end
    return code;
  endfunction

endpackage

FILE: hdl/sirs_div.sv
// shared divide-by-radix unit, one byte of the dividend per cycle
module sirs_div #(
  parameter int DW = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sirs_pkg::div_ctl_t                ctl,
  input  logic [DW-1:0]                     dividend,
  input  logic [sirs_pkg::RADIX_W-1:0]      radix,
  output logic [DW-1:0]                     quotient,
  output logic [sirs_pkg::DIGIT_W-1:0]      remainder,
  output logic                              done
);

  localparam int NCH = DW / sirs_pkg::CHUNK_W;
  localparam int CW = (NCH > 1) ? $clog2(NCH) : 1;

  logic [DW-1:0] dividend_r;
  logic [sirs_pkg::RADIX_W-1:0] radix_r;
  logic [sirs_pkg::DIGIT_W-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic busy_r;
  logic done_r;

  logic [sirs_pkg::CHUNK_W-1:0] q_byte;
  logic [sirs_pkg::DIGIT_W-1:0] rem_step;

  // eight restoring steps on the top byte of the dividend
  always_comb begin
    logic [sirs_pkg::RADIX_W-1:0] r;
    logic [sirs_pkg::RADIX_W-1:0] t;
    r = {1'b0, rem_r};
    q_byte = '0;
    for (int i = sirs_pkg::CHUNK_W - 1; i >= 0; i--) begin
      t = {r[sirs_pkg::DIGIT_W-1:0], dividend_r[DW-sirs_pkg::CHUNK_W+i]};
      if (t >= radix_r) begin
        r = t - radix_r;
        q_byte[i] = 1'b1;
      end else begin
        r = t;
      end
    end
    rem_step = r[sirs_pkg::DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.load || ctl.again) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(NCH - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dividend_r <= dividend;
      radix_r <= radix;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (ctl.again) begin
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      // quotient bytes rotate in at the bottom as dividend bytes leave the top
      dividend_r <= (dividend_r << sirs_pkg::CHUNK_W) | DW'(q_byte);
      rem_r <= rem_step;
      cnt_r <= CW'(cnt_r + 1'b1);
    end
  end

  assign quotient = dividend_r;
  assign remainder = rem_r;
  assign done = done_r;

endmodule

FILE: hdl/sirs_stack.sv
// digit stack: least significant digit pushed first, popped last
module sirs_stack #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  sirs_pkg::stack_ctl_t          ctl,
  input  logic [sirs_pkg::DIGIT_W-1:0]  din,
  output logic [sirs_pkg::DIGIT_W-1:0]  top
);

  logic [sirs_pkg::DIGIT_W-1:0] ent_r [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ent_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        ent_r[i] <= ent_r[i-1];
      end
    end else if (ctl.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
      ent_r[DEPTH-1] <= '0;
    end
  end

  assign top = ent_r[0];

endmodule

FILE: hdl/signed_int_to_radix_string.sv
// signed integer to radix text converter, top level with sequencer and output register
//
// Input transfer: in_tdata carries a signed value and a radix (clamped to 2..16).
// Output: one transfer per ASCII character, a '-' first for negative values,
// then the digits most significant first in 0-9A-F; out_tlast marks the final one.
// Zero gives "0"; the most negative value converts through its unsigned magnitude.
// Digits come from one shared divider that handles one byte of the magnitude per
// cycle, one digit per division. All digits are divided out first, then one
// character is sent per cycle while out_tready is high: up to 33 characters for a
// 32-bit value in radix 2.
// in_tready is high only between items; the next item may enter while the final
// character still waits in the output register. A stall on out_tready holds the
// character in the output register and pauses the character sequence.
// Reset (synchronous, rst_n low) drops any item in flight and clears out_tvalid.
module signed_int_to_radix_string #(
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // value [VALUE_BITS-1:0], base [VALUE_BITS+7:VALUE_BITS], zero fill above
  input  logic [((VALUE_BITS+sirs_pkg::BASE_W+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // char_code [6:0], position [12:7], zero fill [15:13]
  output logic [sirs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic out_tlast
);

  localparam int NCH = (VALUE_BITS + sirs_pkg::CHUNK_W - 1) / sirs_pkg::CHUNK_W;
  localparam int DW = NCH * sirs_pkg::CHUNK_W;
  localparam int NW = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state_r;
  logic out_tvalid_r;
  logic out_tlast_r;
  logic [sirs_pkg::CHAR_W-1:0] out_char_r;
  logic [sirs_pkg::POS_W-1:0] out_pos_r;
  logic [sirs_pkg::POS_W-1:0] pos_r;
  logic [NW-1:0] ndig_r;
  logic sign_pend_r;

  logic accept;
  logic emit_take;
  logic [VALUE_BITS-1:0] raw;
  logic neg;
  logic [VALUE_BITS-1:0] mag;
  logic [sirs_pkg::BASE_W-1:0] base_in;
  logic [sirs_pkg::RADIX_W-1:0] radix;
  logic q_zero;

  sirs_pkg::div_ctl_t div_ctl;
  sirs_pkg::stack_ctl_t stk_ctl;
  logic [DW-1:0] div_q;
  logic [sirs_pkg::DIGIT_W-1:0] div_rem;
  logic div_done;
  logic [sirs_pkg::DIGIT_W-1:0] stk_top;

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    accept = in_tvalid && in_tready;
    raw = in_tdata[VALUE_BITS-1:0];
    neg = raw[VALUE_BITS-1];
    mag = neg ? (~raw + 1'b1) : raw;
    base_in = in_tdata[VALUE_BITS+sirs_pkg::BASE_W-1:VALUE_BITS];
    if (base_in < sirs_pkg::BASE_LO) begin
      radix = sirs_pkg::RADIX_MIN;
    end else if (base_in > sirs_pkg::BASE_HI) begin
      radix = sirs_pkg::RADIX_MAX;
    end else begin
      radix = base_in[sirs_pkg::RADIX_W-1:0];
    end
    q_zero = (div_q == '0);
    emit_take = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);
    div_ctl.load = accept;
    div_ctl.again = (state_r == ST_DIV) && div_done && !q_zero;
    stk_ctl.push = (state_r == ST_DIV) && div_done;
    stk_ctl.pop = emit_take && !sign_pend_r;
  end

  sirs_div #(
    .DW(DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (DW'(mag)),
    .radix     (radix),
    .quotient  (div_q),
    .remainder (div_rem),
    .done      (div_done)
  );

  sirs_stack #(
    .DEPTH(VALUE_BITS)
  ) u_stack (
    .clk (clk),
    .ctl (stk_ctl),
    .din (div_rem),
    .top (stk_top)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      ndig_r <= '0;
      pos_r <= '0;
      sign_pend_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && !emit_take) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            sign_pend_r <= neg;
            ndig_r <= '0;
            pos_r <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            ndig_r <= NW'(ndig_r + 1'b1);
            if (q_zero) begin
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (emit_take) begin
            out_tvalid_r <= 1'b1;
            out_pos_r <= pos_r;
            pos_r <= sirs_pkg::POS_W'(pos_r + 1'b1);
            if (sign_pend_r) begin
              out_char_r <= sirs_pkg::MINUS_CODE;
              out_tlast_r <= 1'b0;
              sign_pend_r <= 1'b0;
            end else begin
              out_char_r <= sirs_pkg::glyph(stk_top);
              out_tlast_r <= (ndig_r == NW'(1));
              ndig_r <= NW'(ndig_r - 1'b1);
              if (ndig_r == NW'(1)) begin
                state_r <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast = out_tlast_r;
  assign out_tdata = {{(sirs_pkg::OUT_DATA_W - sirs_pkg::POS_W - sirs_pkg::CHAR_W){1'b0}},
                      out_pos_r, out_char_r};

endmodule
